>>> rtl/core/hgs_pkg.sv
// Shared types, widths and codes of the hash group-by sum engine.
package hgs_pkg;

    // Table geometry; home slot is taken from the low hash bits, so a power of two
    localparam int TABLE_SLOTS = 1024;
    localparam int SLOT_W      = $clog2(TABLE_SLOTS);

    // Field widths
    localparam int KEY_W    = 32;
    localparam int SUM_W    = 32;
    localparam int IDX_W    = 10;
    localparam int STATUS_W = 3;
    localparam int ENTRY_W  = KEY_W + SUM_W;

    // Stream packing
    localparam int FIELDS_W = KEY_W + SUM_W + IDX_W;
    localparam int TDATA_W  = ((FIELDS_W + 7) / 8) * 8;
    localparam int PAD_W    = TDATA_W - FIELDS_W;

    // Multiplicative hash constant
    localparam logic [KEY_W-1:0] HASH_MULT = 32'h9E37_79B1;

    typedef enum logic [STATUS_W-1:0] {
        STATUS_ADDED    = 3'd0,
        STATUS_NEW      = 3'd1,
        STATUS_FULL     = 3'd2,
        STATUS_RESERVED = 3'd3,
        STATUS_READ     = 3'd4
    } t_status;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_RD,
        ST_CHECK,
        ST_HOLD
    } t_state;

    // One incoming beat
    typedef struct packed {
        logic                    mode;
        logic signed [KEY_W-1:0] group_key;
        logic signed [SUM_W-1:0] amount;
        logic [IDX_W-1:0]        slot_index;
    } t_req;

    // One result beat
    typedef struct packed {
        t_status                 status;
        logic signed [KEY_W-1:0] result_key;
        logic signed [SUM_W-1:0] group_sum;
        logic [IDX_W-1:0]        slot_used;
    } t_res;

endpackage

>>> rtl/core/hash_group_by_sum.sv
// Top level of the hash group-by sum engine: stream ports and output register.
//
//  channel   dir  beat fields (tuser | tdata, lowest bit first)
//  s_axis    in   mode | group_key, amount, slot_index, zero pad
//  m_axis    out  status | result_key, group_sum, slot_used, zero pad
//
// An item walks a linear probe chain in the slot RAM (one read per slot,
// registered read data). After reset a clearing pass over all TABLE_SLOTS
// (1024) slots zeroes the table; no beat is accepted until it ends.
// One item is in work at a time; a new beat is taken while a result waits in
// the output register, and a finished item holds when that register is full.
module hash_group_by_sum (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_s_axis_tvalid,
    output logic                        o_s_axis_tready,
    input  logic [hgs_pkg::TDATA_W-1:0] i_s_axis_tdata,  // group_key, amount, slot_index
    input  logic                        i_s_axis_tuser,  // mode
    output logic                        o_m_axis_tvalid,
    input  logic                        i_m_axis_tready,
    output logic [hgs_pkg::TDATA_W-1:0] o_m_axis_tdata,  // result_key, group_sum, slot_used
    output logic [hgs_pkg::STATUS_W-1:0] o_m_axis_tuser  // status
);
    import hgs_pkg::*;

    t_req w_req;
    t_res w_res;
    t_res r_out;
    logic r_out_valid;
    logic w_ready;
    logic w_start;
    logic w_room;
    logic w_res_valid;

    // Unpack input beat
    assign w_req.mode       = i_s_axis_tuser;
    assign w_req.group_key  = i_s_axis_tdata[KEY_W-1:0];
    assign w_req.amount     = i_s_axis_tdata[KEY_W+SUM_W-1:KEY_W];
    assign w_req.slot_index = i_s_axis_tdata[FIELDS_W-1:KEY_W+SUM_W];

    assign o_s_axis_tready = w_ready;
    assign w_start         = i_s_axis_tvalid && w_ready;
    assign w_room          = !r_out_valid || i_m_axis_tready;

    hgs_probe u_probe (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_start),
        .i_req      (w_req),
        .o_ready    (w_ready),
        .i_res_room (w_room),
        .o_res_valid(w_res_valid),
        .o_res      (w_res)
    );

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_res_valid) begin
            r_out_valid <= 1'b1;
        end else if (i_m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_res_valid) begin
            r_out <= w_res;
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tuser  = r_out.status;
    assign o_m_axis_tdata  = {{PAD_W{1'b0}}, r_out.slot_used, r_out.group_sum, r_out.result_key};

`ifndef SYNTHESIS
    // A result is never loaded over one that has not been taken
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(w_res_valid && r_out_valid && !i_m_axis_tready))
        else $error("result loaded over a pending output beat");

    // One item at a time: ready drops right after a beat is taken
    a_one_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_start |=> !o_s_axis_tready)
        else $error("input accepted while an item is in work");

    // No result can appear in the cycle after an item is taken
    a_min_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_start |=> !w_res_valid)
        else $error("result produced too early");

    // Added and new groups always carry a real key
    a_key_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && (o_m_axis_tuser == STATUS_ADDED || o_m_axis_tuser == STATUS_NEW))
        |-> (o_m_axis_tdata[KEY_W-1:0] != '0))
        else $error("group result with the empty key");
`endif

endmodule

>>> rtl/core/hgs_ram.sv
// Generic simple dual-port RAM, one write port, one registered read port.
module hgs_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Registered read, old data on a same-address collision
    always_ff @(posedge i_clk) begin
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

>>> rtl/core/hgs_hash.sv
// Home-slot hash: registered multiply, then xor-fold and slot select.
module hgs_hash (
    input  logic                       i_clk,
    input  logic                       i_en,
    input  logic [hgs_pkg::KEY_W-1:0]  i_key,
    output logic [hgs_pkg::SLOT_W-1:0] o_home
);
    import hgs_pkg::*;

    logic [KEY_W-1:0] r_prod;
    logic [KEY_W-1:0] w_fold;

    // Low word of key times the golden-ratio constant
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_prod <= i_key * HASH_MULT;
        end
    end

    // h ^ (h >> 16), low bits give the slot
    assign w_fold = r_prod ^ (r_prod >> 16);
    assign o_home = w_fold[SLOT_W-1:0];

endmodule

>>> rtl/core/hgs_probe.sv
// Probe engine: table clearing, linear probe and read-modify-write of the slot RAM.
module hgs_probe (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_start,
    input  hgs_pkg::t_req i_req,
    output logic          o_ready,
    input  logic          i_res_room,
    output logic          o_res_valid,
    output hgs_pkg::t_res o_res
);
    import hgs_pkg::*;

    t_state r_state, n_state;

    // Latched request
    t_req r_req;

    // Probe position and count, clear sweep address
    logic [SLOT_W-1:0] r_pos, n_pos;
    logic [SLOT_W-1:0] r_cnt, n_cnt;
    logic [SLOT_W-1:0] r_clr;

    // Finished result parked while the output is busy
    t_res r_res;
    t_res w_res;
    logic w_done;

    // RAM side
    logic               w_we;
    logic [SLOT_W-1:0]  w_waddr;
    logic [ENTRY_W-1:0] w_wdata;
    logic [SLOT_W-1:0]  w_raddr;
    logic [ENTRY_W-1:0] w_rdata;
    logic [KEY_W-1:0]   w_rd_key;
    logic [SUM_W-1:0]   w_rd_sum;
    logic [SUM_W-1:0]   w_add_sum;

    logic [SLOT_W-1:0]  w_home;
    logic [SLOT_W-1:0]  w_sidx_addr;
    logic               w_sidx_ok;
    logic [SLOT_W-1:0]  w_next_pos;
    logic [IDX_W-1:0]   w_pos_idx;

    hgs_hash u_hash (
        .i_clk (i_clk),
        .i_en  (i_start),
        .i_key (i_req.group_key),
        .o_home(w_home)
    );

    hgs_ram #(
        .WIDTH(ENTRY_W),
        .DEPTH(TABLE_SLOTS)
    ) u_ram (
        .i_clk  (i_clk),
        .i_we   (w_we),
        .i_waddr(w_waddr),
        .i_wdata(w_wdata),
        .i_raddr(w_raddr),
        .o_rdata(w_rdata)
    );

    assign w_rd_key    = w_rdata[ENTRY_W-1:SUM_W];
    assign w_rd_sum    = w_rdata[SUM_W-1:0];
    assign w_add_sum   = w_rd_sum + r_req.amount;
    assign w_sidx_addr = SLOT_W'(r_req.slot_index);
    assign w_sidx_ok   = (32'(r_req.slot_index) < 32'(TABLE_SLOTS));
    assign w_next_pos  = (r_pos == SLOT_W'(TABLE_SLOTS - 1)) ? '0 : r_pos + 1'b1;
    assign w_pos_idx   = IDX_W'(r_pos);

    // State and counters
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_CLEAR;
            r_clr   <= '0;
        end else begin
            r_state <= n_state;
            if (r_state == ST_CLEAR) begin
                r_clr <= r_clr + 1'b1;
            end
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        r_pos <= n_pos;
        r_cnt <= n_cnt;
        if (i_start) begin
            r_req <= i_req;
        end
        if (r_state == ST_CHECK) begin
            r_res <= w_res;
        end
    end

    // Next state, RAM control and result
    always_comb begin
        n_state     = r_state;
        n_pos       = r_pos;
        n_cnt       = r_cnt;
        w_we        = 1'b0;
        w_waddr     = r_pos;
        w_wdata     = '0;
        w_raddr     = r_pos;
        w_done      = 1'b0;
        w_res       = '0;
        o_ready     = 1'b0;
        o_res_valid = 1'b0;
        o_res       = w_res;

        case (r_state)
            ST_CLEAR: begin
                w_we    = 1'b1;
                w_waddr = r_clr;
                if (r_clr == SLOT_W'(TABLE_SLOTS - 1)) begin
                    n_state = ST_IDLE;
                end
            end

            ST_IDLE: begin
                o_ready = 1'b1;
                if (i_start) begin
                    n_state = ST_RD;
                end
            end

            // Issue the first read: requested slot or home slot
            ST_RD: begin
                w_raddr = r_req.mode ? w_sidx_addr : w_home;
                n_pos   = w_raddr;
                n_cnt   = '0;
                n_state = ST_CHECK;
            end

            // Slot data is here: decide, write back, or probe onwards
            ST_CHECK: begin
                if (r_req.mode) begin
                    w_done           = 1'b1;
                    w_res.status     = STATUS_READ;
                    w_res.result_key = w_sidx_ok ? w_rd_key : '0;
                    w_res.group_sum  = w_sidx_ok ? w_rd_sum : '0;
                    w_res.slot_used  = r_req.slot_index;
                end else if (r_req.group_key == '0) begin
                    w_done       = 1'b1;
                    w_res.status = STATUS_RESERVED;
                end else if (w_rd_key == r_req.group_key) begin
                    w_done           = 1'b1;
                    w_we             = 1'b1;
                    w_wdata          = {w_rd_key, w_add_sum};
                    w_res.status     = STATUS_ADDED;
                    w_res.result_key = r_req.group_key;
                    w_res.group_sum  = w_add_sum;
                    w_res.slot_used  = w_pos_idx;
                end else if (w_rd_key == '0) begin
                    w_done           = 1'b1;
                    w_we             = 1'b1;
                    w_wdata          = {r_req.group_key, r_req.amount};
                    w_res.status     = STATUS_NEW;
                    w_res.result_key = r_req.group_key;
                    w_res.group_sum  = r_req.amount;
                    w_res.slot_used  = w_pos_idx;
                end else if (r_cnt == SLOT_W'(TABLE_SLOTS - 1)) begin
                    w_done           = 1'b1;
                    w_res.status     = STATUS_FULL;
                    w_res.result_key = r_req.group_key;
                end else begin
                    w_raddr = w_next_pos;
                    n_pos   = w_next_pos;
                    n_cnt   = r_cnt + 1'b1;
                end

                o_res = w_res;
                if (w_done) begin
                    o_res_valid = i_res_room;
                    n_state     = i_res_room ? ST_IDLE : ST_HOLD;
                end
            end

            ST_HOLD: begin
                o_res       = r_res;
                o_res_valid = i_res_room;
                if (i_res_room) begin
                    n_state = ST_IDLE;
                end
            end

            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

endmodule
